// ===== design/tga_rle_pixel_decoder_unit_macros.svh =====
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder - assertion macros
// Shared concurrent assertion forms used by the decoder modules.
// ----------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_UNIT_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TGARLE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tgarle: check failed");

// Next-cycle implication, disabled while in reset.
`define TGARLE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tgarle: check failed");

`endif

// ===== design/tgarle_pkg.sv =====
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder - package
// Shared types and constants for the front, queue and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

package tgarle_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_HAS_ALPHA   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_TOTAL = 1'b1;

  // Packet header decode: run packets hold header minus this base.
  localparam logic [7:0] RUN_BASE = 8'd127;

  // Slot that completes a pixel.
  localparam logic [1:0] SLOT_LAST_RGB  = 2'd2;
  localparam logic [1:0] SLOT_LAST_RGBA = 2'd3;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // One completed pixel as seen by the back part.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       is_run;
    logic [7:0] count;    // run length; unused for literals
    logic       pkt_end;  // this pixel closes its packet
  } tgarle_pix_t;

endpackage

`default_nettype wire

// ===== design/tgarle_front.sv =====
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder - front part
// Parses packet headers and gathers pixel bytes into completed pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_front
  import tgarle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        has_alpha,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        q_full,
  output logic        q_push,
  output tgarle_pix_t q_data
);

  logic       in_packet;
  logic       is_run;
  logic [7:0] left;
  logic [1:0] slot;
  logic [7:0] blue_q;
  logic [7:0] green_q;
  logic [7:0] red_q;

  logic       accept;
  logic [1:0] final_slot;
  logic       complete;
  logic       pkt_end;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign final_slot = has_alpha ? SLOT_LAST_RGBA : SLOT_LAST_RGB;
  assign complete   = in_packet && (slot >= final_slot);
  assign pkt_end    = is_run || (left == 8'd1);
  assign q_push     = accept && complete;

  always_comb begin
    q_data.blue    = blue_q;
    q_data.green   = green_q;
    q_data.red     = (slot == SLOT_LAST_RGB) ? data_byte : red_q;
    q_data.alpha   = has_alpha ? data_byte : 8'd0;
    q_data.is_run  = is_run;
    q_data.count   = left;
    q_data.pkt_end = pkt_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet <= 1'b0;
      is_run    <= 1'b0;
      left      <= 8'd0;
      slot      <= 2'd0;
    end else if (accept) begin
      if (!in_packet) begin
        // header: bit 7 selects run or raw packet
        in_packet <= 1'b1;
        is_run    <= data_byte[7];
        left      <= data_byte[7] ? (data_byte - RUN_BASE) : (data_byte + 8'd1);
        slot      <= 2'd0;
      end else if (!complete) begin
        slot <= slot + 2'd1;
      end else begin
        slot <= 2'd0;
        left <= is_run ? 8'd0 : (left - 8'd1);
        if (pkt_end) begin
          in_packet <= 1'b0;
        end
      end
    end
  end

  // Pixel byte capture; later slots overwrite nothing earlier.
  always_ff @(posedge clk) begin
    if (accept && in_packet && !complete) begin
      case (slot)
        2'd0:    blue_q  <= data_byte;
        2'd1:    green_q <= data_byte;
        2'd2:    red_q   <= data_byte;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/tgarle_queue.sv =====
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder - pixel queue
// Short queue that decouples the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
`include "tga_rle_pixel_decoder_unit_macros.svh"

module tgarle_queue
  import tgarle_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  tgarle_pix_t push_data,
  output logic        full,
  output logic        valid,
  input  logic        pop,
  output tgarle_pix_t pop_data
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tgarle_pix_t      slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign valid    = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `TGARLE_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

// ===== design/tgarle_back.sv =====
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder - back part
// Applies image progress, clamps runs and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "tga_rle_pixel_decoder_unit_macros.svh"

module tgarle_back
  import tgarle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] pixel_total,
  input  logic        q_valid,
  output logic        q_pop,
  input  tgarle_pix_t q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  blue,
  output logic [7:0]  green,
  output logic [7:0]  red,
  output logic [7:0]  alpha,
  output logic [7:0]  repeat_res,
  output logic        last
);

  logic [31:0] done;
  logic [31:0] done_next;

  logic [31:0] total_eff;
  logic [31:0] rem;
  logic        rem_nz;
  logic        clamp;
  logic [7:0]  rep;
  logic        emit;
  logic        is_last;
  logic        load;

  assign total_eff = (pixel_total == 32'd0) ? 32'd1 : pixel_total;
  assign rem_nz    = (done < total_eff);
  assign rem       = total_eff - done;
  // run reaches or passes the image end
  assign clamp     = rem_nz && (rem[31:8] == 24'd0) && (q_data.count >= rem[7:0]);
  assign emit      = rem_nz;

  always_comb begin
    if (!rem_nz) begin
      rep = 8'd0;
    end else if (q_data.is_run) begin
      rep = clamp ? rem[7:0] : q_data.count;
    end else begin
      rep = 8'd1;
    end
  end

  assign is_last = q_data.is_run ? clamp : (rem == 32'd1);

  always_comb begin
    if (emit) begin
      done_next = (q_data.pkt_end && is_last) ? 32'd0 : (done + {24'd0, rep});
    end else begin
      done_next = q_data.pkt_end ? 32'd0 : done;
    end
  end

  assign load  = q_valid && (!out_valid || out_ready);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 32'd0;
      out_valid <= 1'b0;
    end else if (load) begin
      done      <= done_next;
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      blue       <= q_data.blue;
      green      <= q_data.green;
      red        <= q_data.red;
      alpha      <= q_data.alpha;
      repeat_res <= rep;
      last       <= is_last;
    end
  end

  `TGARLE_ASSERT_IMP(a_rep_range, clk, rst, out_valid,
    (repeat_res != 8'd0) && (repeat_res <= 8'd128))
  `TGARLE_ASSERT_NXT(a_rearm, clk, rst, load && emit && is_last && q_data.pkt_end,
    done == 32'd0)

endmodule

`default_nettype wire

// ===== design/tga_rle_pixel_decoder_unit.sv =====
// A pixel's last byte pushes it into the queue; the back loads it into the result register.
// Throughput: one byte per cycle while the queue has room; one pixel per 3 (RGB) or 4 (RGBA)
// bytes at most. The back drains one entry a cycle unless a held result stalls it.
// Reset (rst, synchronous): has_alpha = 0, pixel_total = 1, parser waits for a header,
// image progress cleared, queue and result register empty.
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder - top level
// Decodes a TGA run-length true-colour byte stream into pixels with repeat counts.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder_unit
  import tgarle_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data,
  // compressed byte stream
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             data_byte,
  // decoded pixels
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             blue,
  output logic [7:0]             green,
  output logic [7:0]             red,
  output logic [7:0]             alpha,
  output logic [7:0]             repeat_res,
  output logic                   last
);

  logic        has_alpha;
  logic [31:0] pixel_total;

  logic        q_full;
  logic        q_push;
  tgarle_pix_t q_in;
  logic        q_valid;
  logic        q_pop;
  tgarle_pix_t q_out;

  // Configuration is always taken, unchecked: it must be written only while the block is idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      has_alpha   <= 1'b0;
      pixel_total <= 32'd1;
    end else if (cfg_valid) begin
      if (cfg_index == REG_HAS_ALPHA) begin
        has_alpha <= cfg_data[0];
      end else if (cfg_index == REG_PIXEL_TOTAL) begin
        pixel_total <= cfg_data;
      end
    end
  end

  // Front: parse headers, gather bytes, push each completed pixel.
  tgarle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .has_alpha (has_alpha),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  // Queue: hold pixels while the result side stalls.
  tgarle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .valid     (q_valid),
    .pop       (q_pop),
    .pop_data  (q_out)
  );

  // Back: track image progress, clamp runs, drop pixels past the end.
  tgarle_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pixel_total (pixel_total),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_data      (q_out),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .blue        (blue),
    .green       (green),
    .red         (red),
    .alpha       (alpha),
    .repeat_res  (repeat_res),
    .last        (last)
  );

endmodule

`default_nettype wire

// ===== tb/tga_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder - pixel checker
// Watches the register, byte and pixel channels. It decodes every accepted
// byte on its own and compares each pixel that leaves the block with the
// oldest pixel still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tga_pixel_checker
  import tgarle_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [7:0]             data_byte,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [7:0]             blue,
  input  logic [7:0]             green,
  input  logic [7:0]             red,
  input  logic [7:0]             alpha,
  input  logic [7:0]             repeat_res,
  input  logic                   last,
  output int                     fail_count,
  output int                     pending
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic [7:0] reps;
    logic       last;
  } pixel_t;

  pixel_t owed_pixels[$];

  // register copies
  logic        alpha_on;
  logic [31:0] total_reg;

  // parser copy
  logic        in_pkt;
  logic        run_pkt;
  logic [7:0]  left_cnt;
  logic [1:0]  slot;
  logic [23:0] gathered;
  logic [31:0] done_cnt;

  task automatic clear_decoder();
    alpha_on  = 1'b0;
    total_reg = 32'd1;
    in_pkt    = 1'b0;
    run_pkt   = 1'b0;
    left_cnt  = 8'd0;
    slot      = 2'd0;
    gathered  = 24'd0;
    done_cnt  = 32'd0;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [31:0] total;
    logic [31:0] remaining;
    logic [31:0] reps;
    logic [1:0]  final_slot;
    logic [7:0]  alpha_val;
    pixel_t      px;
    total      = (total_reg == 32'd0) ? 32'd1 : total_reg;
    final_slot = alpha_on ? SLOT_LAST_RGBA : SLOT_LAST_RGB;
    alpha_val  = 8'd0;
    if (!in_pkt) begin
      // header: top bit set opens a run
      run_pkt  = b[7];
      left_cnt = b[7] ? (b - RUN_BASE) : (b + 8'd1);
      in_pkt   = 1'b1;
      slot     = 2'd0;
      gathered = 24'd0;
    end else if (slot < final_slot) begin
      gathered = gathered | ({16'd0, b} << (8 * slot));
      slot     = slot + 2'd1;
    end else begin
      if (alpha_on)
        alpha_val = b;
      else if (slot != 2'd3)
        gathered = gathered | ({16'd0, b} << (8 * slot));
      remaining = (done_cnt < total) ? (total - done_cnt) : 32'd0;
      if (run_pkt) begin
        reps = {24'd0, left_cnt};
        if (reps > remaining)
          reps = remaining;
        left_cnt = 8'd0;
      end else begin
        reps     = (remaining != 32'd0) ? 32'd1 : 32'd0;
        left_cnt = left_cnt - 8'd1;
      end
      if (reps != 32'd0) begin
        done_cnt = done_cnt + reps;
        px.blue  = gathered[7:0];
        px.green = gathered[15:8];
        px.red   = gathered[23:16];
        px.alpha = alpha_val;
        px.reps  = reps[7:0];
        px.last  = (done_cnt >= total);
        owed_pixels.push_back(px);
      end
      slot = 2'd0;
      if (left_cnt == 8'd0) begin
        in_pkt = 1'b0;
        if (done_cnt >= total)
          done_cnt = 32'd0;
      end
      gathered = 24'd0;
    end
  endtask

  task automatic check_pixel();
    pixel_t px;
    if (owed_pixels.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: pixel with none owed: b=%h g=%h r=%h a=%h rep=%0d last=%b",
                 $realtime, blue, green, red, alpha, repeat_res, last);
    end else begin
      px = owed_pixels.pop_front();
      if (blue !== px.blue || green !== px.green || red !== px.red ||
          alpha !== px.alpha || repeat_res !== px.reps || last !== px.last) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("%0t: pixel mismatch", $realtime);
          $display("  expected b=%h g=%h r=%h a=%h rep=%0d last=%b",
                   px.blue, px.green, px.red, px.alpha, px.reps, px.last);
          $display("  actual   b=%h g=%h r=%h a=%h rep=%0d last=%b",
                   blue, green, red, alpha, repeat_res, last);
        end
      end
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    clear_decoder();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_decoder();
      owed_pixels.delete();
    end else begin
      if (out_valid && out_ready)
        check_pixel();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HAS_ALPHA)
          alpha_on = cfg_data[0];
        else if (cfg_index == REG_PIXEL_TOTAL)
          total_reg = cfg_data;
      end
      if (in_valid && in_ready)
        decode_byte(data_byte);
    end
    pending = owed_pixels.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder - testbench top
// Feeds compressed true-colour byte streams through the decoder: a directed
// pass over header extremes, clamped runs, dropped literals, rearming and
// register changes mid-image, then random images under random back-pressure.
// The checker beside the block decides each pixel; this module only drives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import tgarle_pkg::*;

  // cycles to let a byte already taken work through the pixel queue
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_BYTES  = 800;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [31:0]            cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             data_byte;
  logic                   out_valid;
  logic                   out_ready;
  logic [7:0]             blue;
  logic [7:0]             green;
  logic [7:0]             red;
  logic [7:0]             alpha;
  logic [7:0]             repeat_res;
  logic                   last;
  int                     fail_count;
  int                     pending;

  // mirror of has_alpha, used only to size pixels in the stimulus
  logic cur_alpha;
  int   byte_count;
  bit   in_calm;
  bit   out_calm;

  tga_rle_pixel_decoder_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .blue       (blue),
    .green      (green),
    .red        (red),
    .alpha      (alpha),
    .repeat_res (repeat_res),
    .last       (last)
  );

  tga_pixel_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .blue       (blue),
    .green      (green),
    .red        (red),
    .alpha      (alpha),
    .repeat_res (repeat_res),
    .last       (last),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Offer one byte. Hold valid and the byte until taken; leave valid high
  // afterwards so a back-to-back item needs no drop in between.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 39) == 0)
      in_calm = ~in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    byte_count++;
  endtask

  // One pixel: all bytes random, or all bytes equal to v.
  task automatic send_pixel(input bit rnd, input logic [7:0] v);
    repeat (cur_alpha ? 4 : 3)
      send_byte(rnd ? 8'($urandom_range(0, 255)) : v);
  endtask

  // A well-formed packet of n pixels (1..128) with random colours.
  task automatic send_packet(input bit run, input int n);
    logic [7:0] hdr;
    hdr = run ? (RUN_BASE + n[7:0]) : (n[7:0] - 8'd1);
    send_byte(hdr);
    if (run)
      send_pixel(1'b1, 8'd0);
    else
      repeat (n) send_pixel(1'b1, 8'd0);
  endtask

  // Drop valid, wait for every owed pixel, then let the queue drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Write either register, both or neither, only once the block has gone quiet.
  task automatic write_regs(input bit do_alpha, input logic a,
                            input bit do_total, input logic [31:0] t);
    settle();
    if (do_alpha) begin
      cfg_put(REG_HAS_ALPHA, {31'd0, a});
      cur_alpha = a;
    end
    if (do_total)
      cfg_put(REG_PIXEL_TOTAL, t);
    cfg_valid <= 1'b0;
  endtask

  // Mostly small images so that many complete; now and then a zero total
  // or one so large that it never completes.
  function automatic logic [31:0] pick_total();
    case ($urandom_range(0, 15))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd4294836225;
      3:       return $urandom;
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  // Mostly proper packets; one in sixteen is a burst of stray bytes, which
  // also leaves packets cut short.
  task automatic send_random_packet();
    int kind;
    int n;
    kind = $urandom_range(0, 15);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end else if (kind < 8) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 10);
      send_packet(1'b1, n);
    end else begin
      n = ($urandom_range(0, 59) == 0) ? 128 : $urandom_range(1, 6);
      send_packet(1'b0, n);
    end
  endtask

  // Result side: draw a stall for every pixel, with calm stretches.
  initial begin : result_sink
    int gap;
    out_ready = 1'b0;
    out_calm  = 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0)
        out_calm = ~out_calm;
      gap = out_calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int random_end;
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = REG_HAS_ALPHA;
    cfg_data   = 32'd0;
    in_valid   = 1'b0;
    data_byte  = 8'd0;
    cur_alpha  = 1'b0;
    byte_count = 0;
    in_calm    = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset values: one-pixel image closed by the shortest run.
    send_byte(RUN_BASE + 8'd1);
    send_pixel(1'b0, 8'hFF);

    // Alpha on, three pixels: a single literal of zeros, then the longest
    // run, which has to be clamped to the two pixels still missing.
    write_regs(1'b1, 1'b1, 1'b1, 32'd3);
    send_byte(8'd0);
    send_pixel(1'b0, 8'h00);
    send_byte(8'hFF);
    send_pixel(1'b0, 8'hA5);

    // Literals past the end of the image are swallowed, then rearm.
    write_regs(1'b1, 1'b0, 1'b1, 32'd2);
    send_packet(1'b0, 4);

    // A zero total behaves as one pixel.
    write_regs(1'b0, 1'b0, 1'b1, 32'd0);
    send_packet(1'b1, 5);

    // Lower the total below the progress made inside an open raw packet:
    // the rest of that packet yields nothing and the next image starts clean.
    write_regs(1'b0, 1'b0, 1'b1, 32'd10);
    send_packet(1'b1, 6);
    send_byte(8'd2);
    send_pixel(1'b1, 8'd0);
    write_regs(1'b0, 1'b0, 1'b1, 32'd5);
    repeat (2) send_pixel(1'b1, 8'd0);
    send_packet(1'b1, 2);

    // Switch alpha halfway through a pixel, in both directions.
    write_regs(1'b0, 1'b0, 1'b1, 32'd100);
    send_byte(8'd1);
    repeat (2) send_byte(8'($urandom_range(0, 255)));
    write_regs(1'b1, 1'b1, 1'b0, 32'd0);
    repeat (2) send_byte(8'($urandom_range(0, 255)));
    repeat (3) send_byte(8'($urandom_range(0, 255)));
    write_regs(1'b1, 1'b0, 1'b0, 32'd0);
    send_byte(8'($urandom_range(0, 255)));

    // Random part: open with a full raw packet that overruns a short image,
    // then random settings, each followed by a burst of packets.
    random_end = byte_count + RANDOM_BYTES;
    write_regs(1'b1, 1'($urandom_range(0, 1)), 1'b1, 32'd50);
    send_packet(1'b0, 128);
    while (byte_count < random_end) begin
      write_regs($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
                 $urandom_range(0, 3) != 0, pick_total());
      repeat ($urandom_range(1, 12)) send_random_packet();
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/tgarle_pkg.sv
design/tgarle_front.sv
design/tgarle_queue.sv
design/tgarle_back.sv
design/tga_rle_pixel_decoder_unit.sv
tb/tga_pixel_checker.sv
tb/tb_top.sv
